[sv/zrcl_pkg.sv]
// Package for the ZARC RC ladder step: payload types, tables, sequencer states, helpers.
package zrcl_pkg;

  localparam int TablePoints = 10;
  localparam int RcElements  = 3;
  localparam int SegW        = $clog2(TablePoints);
  localparam int ElW         = $clog2(RcElements + 1);

  localparam logic [16:0] PhiLo = 17'd26214;
  localparam logic [16:0] PhiHi = 17'd65536;

  localparam logic [62:0] MagLimit = 63'h4000_0000_0000_0000;
  localparam logic [47:0] CapMax   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] CapMin   = 48'h8000_0000_0000;

  localparam logic [16:0] PhiPts [TablePoints] = '{
    17'd26214, 17'd32768, 17'd39322, 17'd45875, 17'd52429,
    17'd58982, 17'd60293, 17'd61604, 17'd62915, 17'd65536};
  localparam logic [31:0] TauFac [TablePoints] = '{
    32'd2619749, 32'd1431070, 32'd892509, 32'd604967, 32'd431466,
    32'd316666, 32'd298202, 32'd280885, 32'd264599, 32'd249237};
  localparam logic [31:0] OuterFac [TablePoints] = '{
    32'd18405, 32'd17390, 32'd16030, 32'd14140, 32'd11424,
    32'd7246, 32'd6127, 32'd4873, 32'd3458, 32'd1848};
  localparam logic [31:0] InnerFac [TablePoints] = '{
    32'd25974, 32'd29022, 32'd32415, 32'd36637, 32'd42363,
    32'd50913, 32'd53182, 32'd55719, 32'd58575, 32'd61818};

  // Factor table selectors
  localparam logic [1:0] TabOuter = 2'd0;
  localparam logic [1:0] TabInner = 2'd1;
  localparam logic [1:0] TabTau   = 2'd2;

  // Scaling products
  localparam logic [2:0] ScRout = 3'd0;
  localparam logic [2:0] ScRin  = 3'd1;
  localparam logic [2:0] ScSer0 = 3'd2;
  localparam logic [2:0] ScSer1 = 3'd3;
  localparam logic [2:0] ScTau0 = 3'd4;

  typedef struct packed {
    logic signed [31:0] current_in;
    logic [16:0]        phase_exponent;
    logic [31:0]        base_resistance;
    logic [31:0]        relax_time;
    logic [31:0]        step_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] voltage_out;
    logic [31:0]        power_out;
    logic               overflow_flag;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_IP_MUL, ST_IP_DIV, ST_IP_FIN, ST_SC_MUL, ST_SC_FIN,
    ST_TAU_DIV, ST_TAU_FIN, ST_EL_CHECK, ST_G_DIV, ST_U_MUL, ST_U_FIN,
    ST_E_MUL, ST_E_FIN, ST_SER_MUL, ST_SER_FIN, ST_PW_SQ, ST_PW_MUL, ST_PW_FIN
  } state_e;

  typedef struct packed {
    logic        sat;
    logic [62:0] mag;
  } shr_res_t;

  // Shift a product right and limit its magnitude to 2^62.
  function automatic shr_res_t sat_shr(input logic [127:0] prod, input logic [5:0] sh);
    logic [127:0] s;
    shr_res_t     r;
    s     = prod >> sh;
    r.sat = |s[127:62];
    r.mag = r.sat ? MagLimit : s[62:0];
    return r;
  endfunction

  function automatic logic [31:0] tab_val(input logic [1:0] tab, input logic [SegW-1:0] i);
    logic [31:0] v;
    case (tab)
      TabOuter: v = OuterFac[i];
      TabInner: v = InnerFac[i];
      default:  v = TauFac[i];
    endcase
    return v;
  endfunction

endpackage

[sv/zarc_rc_ladder_step_top.sv]
// Top level of the ZARC RC ladder step: sequencer, shared multiplier and shared divider.
// Work per request: three table interpolations and one time constant on the shared divider,
//   one step ratio per active element, and a series drop when fewer than three are active.
// The input stalls while a request is in work; a new request is taken once the last result is loaded.
// Reset (rst_ni low, asynchronous): capacitor voltages clear, active_elements becomes 3.
module zarc_rc_ladder_step_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  zrcl_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output zrcl_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_wdata_i
);

  zrcl_pkg::state_e state_q, state_d;
  logic adv;

  // Request latch and interpolation state
  zrcl_pkg::in_t                 in_q;
  logic [16:0]                   p_q;
  logic [zrcl_pkg::SegW-1:0]     seg_q;
  logic [1:0]                    tab_idx_q;
  logic [2:0]                    sc_idx_q;
  logic [zrcl_pkg::ElW-1:0]      el_q;
  logic [1:0]                    active_q;

  logic [15:0] fac_a_q, fac_b_q;
  logic [21:0] fac_k_q;
  logic [31:0] r_out_q, r_in_q, tau2_q;
  logic [33:0] ser0_q;
  logic [32:0] ser1_q;
  logic [37:0] tau0_q;

  logic signed [47:0] cap_q [zrcl_pkg::RcElements];
  logic [63:0] u_q, sum_q;
  logic        e_neg_q, sat_q;

  // Shared multiplier: 64x64 from four 32x32 partial products
  logic [63:0]  mul_a_q, mul_b_q;
  logic [127:0] mul_acc_q;
  logic [1:0]   mul_cnt_q;
  logic         mul_run_q;
  logic         mul_go;
  logic [63:0]  mul_opa, mul_opb;
  logic [31:0]  mul_ha, mul_hb;
  logic [63:0]  mul_pp;
  logic [127:0] mul_pp_sh;

  // Shared divider: restoring, one quotient bit a cycle
  logic [63:0] div_num_q, div_den_q, div_rem_q;
  logic [5:0]  div_cnt_q;
  logic        div_run_q;
  logic        div_go;
  logic [63:0] div_opn, div_opd;
  logic [64:0] div_trial;
  logic        div_qbit;

  zrcl_pkg::out_t out_q;
  logic           out_valid_q;

  // Combinational datapath helpers
  logic [16:0]               p_clamp;
  logic [zrcl_pkg::SegW-1:0] seg_d;
  logic [zrcl_pkg::SegW-1:0] seg_nx;
  logic [31:0]               tab_lo, tab_hi;
  logic [32:0]               dy;
  logic [31:0]               dy_mag;
  logic [16:0]               t_off, dx;
  logic [31:0]               fac_new;
  logic [31:0]               cur_mag;
  logic                      cur_neg;
  logic [63:0]               tau_sel, tgt_sel, ser_sel;
  logic [63:0]               cap_ext, e_val, e_mag;
  zrcl_pkg::shr_res_t        shr8, shr32, shr40;
  logic [63:0]               u_mag64, u_new, d_mag64, d_val, nv;
  logic                      nv_fits;
  logic [47:0]               nv_sat, vs;
  logic [63:0]               ser_term;
  logic                      v_fits, pw_big;

  assign in_stall_o  = (state_q != zrcl_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Clamp phi and find its table segment
  always_comb begin
    p_clamp = in_data_i.phase_exponent;
    if (p_clamp < zrcl_pkg::PhiLo) p_clamp = zrcl_pkg::PhiLo;
    if (p_clamp > zrcl_pkg::PhiHi) p_clamp = zrcl_pkg::PhiHi;
    seg_d = '0;
    for (int i = 0; i < zrcl_pkg::TablePoints - 1; i++) begin
      if (zrcl_pkg::PhiPts[i] <= p_clamp) seg_d = zrcl_pkg::SegW'(i);
    end
  end

  // Interpolation terms for the table in hand
  always_comb begin
    seg_nx  = seg_q + zrcl_pkg::SegW'(1);
    tab_lo  = zrcl_pkg::tab_val(tab_idx_q, seg_q);
    tab_hi  = zrcl_pkg::tab_val(tab_idx_q, seg_nx);
    dy      = {1'b0, tab_hi} - {1'b0, tab_lo};
    dy_mag  = dy[32] ? 32'(~dy + 33'd1) : dy[31:0];
    t_off   = p_q - zrcl_pkg::PhiPts[seg_q];
    dx      = zrcl_pkg::PhiPts[seg_nx] - zrcl_pkg::PhiPts[seg_q];
    fac_new = dy[32] ? (tab_lo - div_num_q[31:0]) : (tab_lo + div_num_q[31:0]);
  end

  // Element terms
  always_comb begin
    cur_neg = in_q.current_in[31];
    cur_mag = cur_neg ? 32'(~in_q.current_in + 32'sd1) : in_q.current_in;
    case (el_q)
      2'd0:    tau_sel = 64'(tau0_q);
      2'd1:    tau_sel = 64'(in_q.relax_time);
      default: tau_sel = 64'(tau2_q);
    endcase
    tgt_sel = (el_q == 2'd1) ? 64'(r_in_q) : 64'(r_out_q);
    case (active_q)
      2'd0:    ser_sel = 64'(ser0_q);
      2'd1:    ser_sel = 64'(ser1_q);
      default: ser_sel = 64'(r_out_q);
    endcase
    cap_ext = {{16{cap_q[el_q][47]}}, cap_q[el_q]};
    e_val   = u_q - cap_ext;
    e_mag   = e_val[63] ? (~e_val + 64'd1) : e_val;

    shr8    = zrcl_pkg::sat_shr(mul_acc_q, 6'd8);
    shr32   = zrcl_pkg::sat_shr(mul_acc_q, 6'd32);
    shr40   = zrcl_pkg::sat_shr(mul_acc_q, 6'd40);

    u_mag64 = {1'b0, shr8.mag};
    u_new   = cur_neg ? (~u_mag64 + 64'd1) : u_mag64;
    ser_term = u_new;

    d_mag64 = {1'b0, shr32.mag};
    d_val   = e_neg_q ? (~d_mag64 + 64'd1) : d_mag64;
    nv      = cap_ext + d_val;
    nv_fits = (&nv[63:47]) || (~|nv[63:47]);
    nv_sat  = nv_fits ? nv[47:0] : (nv[63] ? zrcl_pkg::CapMin : zrcl_pkg::CapMax);

    vs      = sum_q[63:16];
    v_fits  = (&vs[47:31]) || (~|vs[47:31]);
    pw_big  = |shr40.mag[62:32];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    adv     = 1'b0;
    unique case (state_q)
      zrcl_pkg::ST_IDLE: begin
        adv = in_valid_i;
        if (adv) state_d = zrcl_pkg::ST_IP_MUL;
      end
      zrcl_pkg::ST_IP_MUL: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_IP_DIV;
      end
      zrcl_pkg::ST_IP_DIV: begin
        adv = !mul_run_q;
        if (adv) state_d = zrcl_pkg::ST_IP_FIN;
      end
      zrcl_pkg::ST_IP_FIN: begin
        adv = !div_run_q;
        if (adv) state_d = (tab_idx_q == zrcl_pkg::TabTau) ? zrcl_pkg::ST_SC_MUL
                                                           : zrcl_pkg::ST_IP_MUL;
      end
      zrcl_pkg::ST_SC_MUL: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_SC_FIN;
      end
      zrcl_pkg::ST_SC_FIN: begin
        adv = !mul_run_q;
        if (adv) state_d = (sc_idx_q == zrcl_pkg::ScTau0) ? zrcl_pkg::ST_TAU_DIV
                                                          : zrcl_pkg::ST_SC_MUL;
      end
      zrcl_pkg::ST_TAU_DIV: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_TAU_FIN;
      end
      zrcl_pkg::ST_TAU_FIN: begin
        adv = !div_run_q;
        if (adv) state_d = zrcl_pkg::ST_EL_CHECK;
      end
      zrcl_pkg::ST_EL_CHECK: begin
        adv = 1'b1;
        if (el_q < active_q)         state_d = zrcl_pkg::ST_G_DIV;
        else if (active_q != 2'd3)   state_d = zrcl_pkg::ST_SER_MUL;
        else                         state_d = zrcl_pkg::ST_PW_SQ;
      end
      zrcl_pkg::ST_G_DIV: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_U_MUL;
      end
      zrcl_pkg::ST_U_MUL: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_U_FIN;
      end
      zrcl_pkg::ST_U_FIN: begin
        adv = !mul_run_q;
        if (adv) state_d = zrcl_pkg::ST_E_MUL;
      end
      zrcl_pkg::ST_E_MUL: begin
        adv = !div_run_q;
        if (adv) state_d = zrcl_pkg::ST_E_FIN;
      end
      zrcl_pkg::ST_E_FIN: begin
        adv = !mul_run_q;
        if (adv) state_d = zrcl_pkg::ST_EL_CHECK;
      end
      zrcl_pkg::ST_SER_MUL: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_SER_FIN;
      end
      zrcl_pkg::ST_SER_FIN: begin
        adv = !mul_run_q;
        if (adv) state_d = zrcl_pkg::ST_PW_SQ;
      end
      zrcl_pkg::ST_PW_SQ: begin
        adv = 1'b1;
        state_d = zrcl_pkg::ST_PW_MUL;
      end
      zrcl_pkg::ST_PW_MUL: begin
        adv = !mul_run_q;
        if (adv) state_d = zrcl_pkg::ST_PW_FIN;
      end
      zrcl_pkg::ST_PW_FIN: begin
        // Hold until the product is in and the output register is free
        adv = !mul_run_q && (!out_valid_q || !out_stall_i);
        if (adv) state_d = zrcl_pkg::ST_IDLE;
      end
      default: begin
        state_d = zrcl_pkg::ST_IDLE;
      end
    endcase
  end

  // Unit issue and operand selection
  always_comb begin
    mul_go  = 1'b0;
    mul_opa = '0;
    mul_opb = '0;
    div_go  = 1'b0;
    div_opn = '0;
    div_opd = '0;
    unique case (state_q)
      zrcl_pkg::ST_IP_MUL: begin
        mul_go  = 1'b1;
        mul_opa = 64'(dy_mag);
        mul_opb = 64'(t_off);
      end
      zrcl_pkg::ST_IP_DIV: begin
        div_go  = adv;
        div_opn = mul_acc_q[63:0];
        div_opd = 64'(dx);
      end
      zrcl_pkg::ST_SC_MUL: begin
        mul_go = 1'b1;
        case (sc_idx_q)
          zrcl_pkg::ScRout: begin
            mul_opa = 64'(fac_a_q);
            mul_opb = 64'(in_q.base_resistance);
          end
          zrcl_pkg::ScRin: begin
            mul_opa = 64'(fac_b_q);
            mul_opb = 64'(in_q.base_resistance);
          end
          zrcl_pkg::ScSer0: begin
            mul_opa = 64'({fac_a_q, 1'b0}) + 64'(fac_b_q);
            mul_opb = 64'(in_q.base_resistance);
          end
          zrcl_pkg::ScSer1: begin
            mul_opa = 64'(fac_a_q) + 64'(fac_b_q);
            mul_opb = 64'(in_q.base_resistance);
          end
          default: begin
            mul_opa = 64'(fac_k_q);
            mul_opb = 64'(in_q.relax_time);
          end
        endcase
      end
      zrcl_pkg::ST_TAU_DIV: begin
        div_go  = 1'b1;
        div_opn = {16'd0, in_q.relax_time, 16'd0};
        div_opd = 64'(fac_k_q);
      end
      zrcl_pkg::ST_G_DIV: begin
        // A time constant that truncated to zero counts as one LSB
        div_go  = 1'b1;
        div_opn = {in_q.step_time, 32'd0};
        div_opd = (tau_sel == 64'd0) ? 64'd1 : tau_sel;
      end
      zrcl_pkg::ST_U_MUL: begin
        mul_go  = 1'b1;
        mul_opa = 64'(cur_mag);
        mul_opb = tgt_sel;
      end
      zrcl_pkg::ST_E_MUL: begin
        mul_go  = adv;
        mul_opa = e_mag;
        mul_opb = div_num_q;
      end
      zrcl_pkg::ST_SER_MUL: begin
        mul_go  = 1'b1;
        mul_opa = 64'(cur_mag);
        mul_opb = ser_sel;
      end
      zrcl_pkg::ST_PW_SQ: begin
        mul_go  = 1'b1;
        mul_opa = 64'(cur_mag);
        mul_opb = 64'(cur_mag);
      end
      zrcl_pkg::ST_PW_MUL: begin
        mul_go  = adv;
        mul_opa = mul_acc_q[63:0];
        mul_opb = 64'(ser0_q);
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  // Partial product for the current step of the multiplier, and the divider's trial subtraction
  always_comb begin
    mul_ha = mul_cnt_q[1] ? mul_a_q[63:32] : mul_a_q[31:0];
    mul_hb = mul_cnt_q[0] ? mul_b_q[63:32] : mul_b_q[31:0];
    mul_pp = 64'(mul_ha) * 64'(mul_hb);
    case (mul_cnt_q)
      2'd0:    mul_pp_sh = {64'd0, mul_pp};
      2'd3:    mul_pp_sh = {mul_pp, 64'd0};
      default: mul_pp_sh = {32'd0, mul_pp, 32'd0};
    endcase
    div_trial = {div_rem_q, div_num_q[63]};
    div_qbit  = (div_trial >= {1'b0, div_den_q});
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zrcl_pkg::ST_IDLE;
      mul_run_q   <= 1'b0;
      mul_cnt_q   <= '0;
      div_run_q   <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      active_q    <= 2'd3;
      for (int i = 0; i < zrcl_pkg::RcElements; i++) cap_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;

      if (mul_go) begin
        mul_run_q <= 1'b1;
        mul_cnt_q <= '0;
      end else if (mul_run_q) begin
        mul_cnt_q <= mul_cnt_q + 2'd1;
        if (&mul_cnt_q) mul_run_q <= 1'b0;
      end

      if (div_go) begin
        div_run_q <= 1'b1;
        div_cnt_q <= '0;
      end else if (div_run_q) begin
        div_cnt_q <= div_cnt_q + 6'd1;
        if (&div_cnt_q) div_run_q <= 1'b0;
      end

      // Drop a taken result; load a finished one
      if (state_q == zrcl_pkg::ST_PW_FIN && adv) out_valid_q <= 1'b1;
      else if (!out_stall_i)                     out_valid_q <= 1'b0;

      if (state_q == zrcl_pkg::ST_E_FIN && adv) cap_q[el_q] <= nv_sat;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      mul_a_q   <= mul_opa;
      mul_b_q   <= mul_opb;
      mul_acc_q <= '0;
    end else if (mul_run_q) begin
      mul_acc_q <= mul_acc_q + mul_pp_sh;
    end

    if (div_go) begin
      div_num_q <= div_opn;
      div_den_q <= div_opd;
      div_rem_q <= '0;
    end else if (div_run_q) begin
      div_rem_q <= div_qbit ? 64'(div_trial - {1'b0, div_den_q}) : div_trial[63:0];
      div_num_q <= {div_num_q[62:0], div_qbit};
    end

    if (adv) begin
      unique case (state_q)
        zrcl_pkg::ST_IDLE: begin
          in_q      <= in_data_i;
          p_q       <= p_clamp;
          seg_q     <= seg_d;
          tab_idx_q <= zrcl_pkg::TabOuter;
          sc_idx_q  <= zrcl_pkg::ScRout;
          el_q      <= '0;
          sum_q     <= '0;
          sat_q     <= 1'b0;
        end
        zrcl_pkg::ST_IP_FIN: begin
          case (tab_idx_q)
            zrcl_pkg::TabOuter: fac_a_q <= fac_new[15:0];
            zrcl_pkg::TabInner: fac_b_q <= fac_new[15:0];
            default:            fac_k_q <= fac_new[21:0];
          endcase
          tab_idx_q <= tab_idx_q + 2'd1;
        end
        zrcl_pkg::ST_SC_FIN: begin
          case (sc_idx_q)
            zrcl_pkg::ScRout: r_out_q <= mul_acc_q[47:16];
            zrcl_pkg::ScRin:  r_in_q  <= mul_acc_q[47:16];
            zrcl_pkg::ScSer0: ser0_q  <= mul_acc_q[49:16];
            zrcl_pkg::ScSer1: ser1_q  <= mul_acc_q[48:16];
            default:          tau0_q  <= mul_acc_q[53:16];
          endcase
          sc_idx_q <= sc_idx_q + 3'd1;
        end
        zrcl_pkg::ST_TAU_FIN: begin
          tau2_q <= div_num_q[31:0];
        end
        zrcl_pkg::ST_U_FIN: begin
          u_q <= u_new;
          if (shr8.sat) sat_q <= 1'b1;
        end
        zrcl_pkg::ST_E_MUL: begin
          e_neg_q <= e_val[63];
        end
        zrcl_pkg::ST_E_FIN: begin
          sum_q <= sum_q + {{16{nv_sat[47]}}, nv_sat};
          el_q  <= el_q + zrcl_pkg::ElW'(1);
          if (shr32.sat || !nv_fits) sat_q <= 1'b1;
        end
        zrcl_pkg::ST_SER_FIN: begin
          // Fold the inactive elements in as a series drop
          sum_q <= sum_q + ser_term;
          if (shr8.sat) sat_q <= 1'b1;
        end
        zrcl_pkg::ST_PW_FIN: begin
          out_q.voltage_out   <= v_fits ? vs[31:0] : (vs[47] ? 32'h8000_0000 : 32'h7FFF_FFFF);
          out_q.power_out     <= pw_big ? 32'hFFFF_FFFF : shr40.mag[31:0];
          out_q.overflow_flag <= sat_q || shr40.sat || pw_big || !v_fits;
        end
        default: begin
          sat_q <= sat_q;
        end
      endcase
    end
  end

endmodule

[sv/zrcl_checker.sv]
// Port checker for the ZARC RC ladder step and its bind to the top level.
module zrcl_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input zrcl_pkg::out_t out_data_o
);

  // A request that is taken keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Busy only begins with a request
  a_busy_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("busy without request");

  // A result appears only at the end of work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind zarc_rc_ladder_step_top zrcl_port_checker u_zrcl_checker (.*);

[tb/zrcl_checker.sv]
// Checker for the ZARC RC ladder step: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps
module zrcl_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  zrcl_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  zrcl_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             results_seen_o
);

  localparam logic [31:0] PhiPtsC [zrcl_pkg::TablePoints] = '{
    26214, 32768, 39322, 45875, 52429, 58982, 60293, 61604, 62915, 65536};
  localparam logic [31:0] TauC [zrcl_pkg::TablePoints] = '{
    2619749, 1431070, 892509, 604967, 431466, 316666, 298202, 280885, 264599, 249237};
  localparam logic [31:0] OuterC [zrcl_pkg::TablePoints] = '{
    18405, 17390, 16030, 14140, 11424, 7246, 6127, 4873, 3458, 1848};
  localparam logic [31:0] InnerC [zrcl_pkg::TablePoints] = '{
    25974, 29022, 32415, 36637, 42363, 50913, 53182, 55719, 58575, 61818};
  localparam logic signed [63:0] CapHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] CapLo = -CapHi - 1;

  logic signed [63:0]  cap_v [zrcl_pkg::RcElements];
  logic [1:0]          n_active;
  bit                  clipped;
  zrcl_pkg::out_t      expected_q [$];

  function automatic logic [63:0] mag_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (|p[127:62]) begin
      clipped = 1;
      return 64'd1 << 62;
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] signed_shift(logic signed [63:0] s, logic [63:0] u,
                                                    int sh);
    logic [63:0] m;
    m = mag_shift(s < 0 ? -s : s, u, sh);
    return s < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] lerp(int which, logic [31:0] p);
    int seg;
    logic signed [63:0] y0, y1, dy, dx, t;
    seg = 0;
    for (int i = 0; i + 1 < zrcl_pkg::TablePoints; i++)
      if (PhiPtsC[i] <= p) seg = i;
    case (which)
      0: begin y0 = OuterC[seg]; y1 = OuterC[seg+1]; end
      1: begin y0 = InnerC[seg]; y1 = InnerC[seg+1]; end
      default: begin y0 = TauC[seg]; y1 = TauC[seg+1]; end
    endcase
    dy = y1 - y0;
    dx = PhiPtsC[seg+1] - PhiPtsC[seg];
    t  = p - PhiPtsC[seg];
    return y0 + (dy * t) / dx;  // SV division truncates toward zero
  endfunction

  function automatic zrcl_pkg::out_t ladder_step(zrcl_pkg::in_t x);
    logic [31:0] p;
    logic [63:0] a, b, k, res, tc, dt, r_out, tl, g, pw, mg;
    logic [63:0] tgt [zrcl_pkg::RcElements];
    logic [63:0] tau [zrcl_pkg::RcElements];
    logic [63:0] ser [zrcl_pkg::RcElements];
    logic signed [63:0] cur, sum, u, e, nv, vo;
    zrcl_pkg::out_t r;
    clipped = 0;
    cur = x.current_in;
    p = x.phase_exponent;
    if (p < 26214) p = 26214;
    if (p > 65536) p = 65536;
    a = lerp(0, p); b = lerp(1, p); k = lerp(2, p);
    res = x.base_resistance; tc = x.relax_time; dt = x.step_time;
    r_out = (a * res) >> 16;
    tgt[0] = r_out; tgt[1] = (b * res) >> 16; tgt[2] = r_out;
    tau[0] = (k * tc) >> 16; tau[1] = tc; tau[2] = (tc << 16) / k;
    ser[0] = ((2 * a + b) * res) >> 16;
    ser[1] = ((a + b) * res) >> 16;
    ser[2] = r_out;
    sum = 0;
    for (int i = 0; i < n_active; i++) begin
      tl = tau[i] == 0 ? 64'd1 : tau[i];
      g  = (dt << 32) / tl;
      u  = signed_shift(cur, tgt[i], 8);
      e  = u - cap_v[i];
      nv = cap_v[i] + signed_shift(e, g, 32);
      if (nv > CapHi) begin nv = CapHi; clipped = 1; end
      if (nv < CapLo) begin nv = CapLo; clipped = 1; end
      cap_v[i] = nv;
      sum += nv;
    end
    if (n_active < 3) sum += signed_shift(cur, ser[n_active], 8);
    vo = sum >>> 16;  // arithmetic shift floors
    if (vo > 64'sh7FFF_FFFF) begin vo = 64'sh7FFF_FFFF; clipped = 1; end
    if (vo < -64'sh8000_0000) begin vo = -64'sh8000_0000; clipped = 1; end
    mg = cur < 0 ? -cur : cur;
    pw = mag_shift(mg * mg, ser[0], 40);
    if (pw > 64'hFFFF_FFFF) begin pw = 64'hFFFF_FFFF; clipped = 1; end
    r.voltage_out   = vo[31:0];
    r.power_out     = pw[31:0];
    r.overflow_flag = clipped;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    zrcl_pkg::out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < zrcl_pkg::RcElements; i++) cap_v[i] = 0;
      n_active = 2'd3;
      expected_q.delete();
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.voltage_out !== want.voltage_out) begin
            $error("voltage_out expected %h actual %h", want.voltage_out,
                   out_data_i.voltage_out);
            fail_count_o++;
          end
          if (out_data_i.power_out !== want.power_out) begin
            $error("power_out expected %h actual %h", want.power_out, out_data_i.power_out);
            fail_count_o++;
          end
          if (out_data_i.overflow_flag !== want.overflow_flag) begin
            $error("overflow_flag expected %b actual %b", want.overflow_flag,
                   out_data_i.overflow_flag);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) n_active = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) expected_q = {expected_q, ladder_step(in_data_i)};
    end
    pending_o = expected_q.size();
  end
endmodule

[tb/tb_top.sv]
// Testbench top for the ZARC RC ladder step: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic out_stall_i = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_wdata_i = 0;
  zrcl_pkg::in_t  in_data_i = '0;
  logic in_stall_o, out_valid_o;
  zrcl_pkg::out_t out_data_o;
  int   fail_count, pending, results_seen;

  // Idle rates in percent; the hold-off flag freezes the receiver outright.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  n_requests = 0;

  always #1 clk_i = ~clk_i;

  zarc_rc_ladder_step_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  zrcl_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen)
  );

  // Receiver stall: random per cycle, or held high during a hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one request; random gaps first, then hold until accepted.
  // Valid stays high after the accept so that back-to-back requests need no gap.
  task automatic send_request(zrcl_pkg::in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    n_requests++;
  endtask

  // Drop valid, drain all expectations, then let the block settle before a register write.
  task automatic drain_then_write(logic [1:0] v);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1 << 20);
      3: return 32'h0001_0000 + $urandom_range(1 << 18);
      default: return $urandom;
    endcase
  endfunction

  // Mostly realistic magnitudes, with full-range values now and then.
  function automatic zrcl_pkg::in_t rand_request();
    zrcl_pkg::in_t x;
    x.current_in      = ($urandom_range(3) == 0) ? $urandom
                        : $signed($urandom_range(1 << 22)) - (1 << 21);
    x.phase_exponent  = ($urandom_range(4) == 0) ? 17'($urandom)
                        : 17'($urandom_range(65536, 20000));
    x.base_resistance = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 26);
    x.relax_time      = rand_word();
    x.step_time       = rand_word();
    if (x.relax_time == 0 && $urandom_range(1)) x.relax_time = 1;
    return x;
  endfunction

  function automatic zrcl_pkg::in_t mk(logic [31:0] c, logic [16:0] p, logic [31:0] r,
                                       logic [31:0] t, logic [31:0] d);
    zrcl_pkg::in_t x;
    x.current_in = c; x.phase_exponent = p; x.base_resistance = r;
    x.relax_time = t; x.step_time = d;
    return x;
  endfunction

  initial begin
    logic [1:0] cfg_seq [5];
    cfg_seq = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes, phi clamping both ends, zero tau and zero step,
    // a huge step ratio that overshoots, and saturating power.
    send_request(mk(32'h0001_0000, 17'd0, 32'h0100_0000, 32'h0001_0000, 32'h0000_1000));
    send_request(mk(32'h7FFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(mk(32'h8000_0000, 17'd65536, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    send_request(mk(32'hFFFF_0000, 17'd26214, 32'h0100_0000, 32'd1, 32'd0));
    send_request(mk(32'h0000_0000, 17'd45875, 32'd0, 32'd1, 32'd1));
    send_request(mk(32'h0010_0000, 17'd60000, 32'h0200_0000, 32'd1, 32'hFFFF_FFFF));
    send_request(mk(32'hFFFF_FFFF, 17'd65535, 32'h0080_0000, 32'h0000_0100, 32'h0001_0000));
    for (int i = 0; i < 5; i++) begin
      drain_then_write(cfg_seq[i]);
      send_request(mk(32'h0003_0000, 17'd40000, 32'h0100_0000, 32'h0002_0000, 32'h0000_8000));
      send_request(mk(32'hFFFC_0000, 17'd70000, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    end

    // Random phases: sender idles lightly, then the receiver; then neither.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 9 : 0;
      for (int c = 0; c < 4; c++) begin
        drain_then_write(2'($urandom_range(3)));
        for (int j = 0; j < 157; j++) send_request(rand_request());
      end
    end

    // Hold off the receiver for a long stretch while requests keep coming.
    fork
      begin
        recv_hold = 1;
        repeat (3000) @(posedge clk_i);
        recv_hold = 0;
      end
      for (int j = 0; j < 8; j++) send_request(rand_request());
    join

    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d requests and %0d results over all element counts and idle patterns.",
             n_requests, results_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout far above the worst-case work per request with 67 percent stalls; it reports a failure.
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
